// File: hw/rtl/lufcs_pkg.sv
// shared widths, constants and helpers for the least-used flow cover selector
// no dependencies; used by the channel interfaces and the top level
package lufcs_pkg;

    localparam int LUFCS_FLOWS         = 64;
    localparam int FLOW_INDEX_W        = 6;
    localparam int ADDR_W              = 32;
    localparam int LENGTH_W            = 16;
    localparam int DRAW_W              = 7;
    localparam int PROB_W              = 7;
    localparam int COUNT_W             = 32;
    localparam logic [PROB_W-1:0] PROB_RESET = 7'd100;
    localparam logic [COUNT_W-1:0] COVER_HEADER_BYTES = 32'd54;

    // saturating add of two byte counts
    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0] a,
        input logic [COUNT_W-1:0] b
    );
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/lufcs_pkt_if.sv
// packet event channel: valid/ready handshake plus the packet fields
// depends on lufcs_pkg for field widths
interface lufcs_pkt_if
    import lufcs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [FLOW_INDEX_W-1:0] flow_index;
    logic [ADDR_W-1:0]       source_address;
    logic [LENGTH_W-1:0]     packet_length;
    logic [DRAW_W-1:0]       random_draw;

    modport source (
        output valid, flow_index, source_address, packet_length, random_draw,
        input  ready
    );

    modport sink (
        input  valid, flow_index, source_address, packet_length, random_draw,
        output ready
    );
endinterface

// File: hw/rtl/lufcs_res_if.sv
// result channel: valid/ready handshake plus the cover or pass result fields
// depends on lufcs_pkg for field widths
interface lufcs_res_if
    import lufcs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    is_cover;
    logic [FLOW_INDEX_W-1:0] chosen_flow;
    logic [ADDR_W-1:0]       cover_source;
    logic                    last;

    modport source (
        output valid, is_cover, chosen_flow, cover_source, last,
        input  ready
    );

    modport sink (
        input  valid, is_cover, chosen_flow, cover_source, last,
        output ready
    );
endinterface

// File: hw/rtl/least_used_flow_cover_selector.sv
// least-used flow cover selector: per-flow byte counters, cover flow search
// depends on lufcs_pkg, lufcs_pkt_if and lufcs_res_if
//
// One packet request is taken at a time. The per-flow byte counter and stored
// source address share one synchronous memory of FLOWS entries with a single
// registered read port; an entry-valid flop per flow, cleared at reset, makes
// unwritten entries read as zero, so no clearing pass is needed.
// A packet that does not trigger a cover request goes through the own-flow read
// and update to its pass result. A triggered packet goes on through the scan,
// the drain and the read and update of the chosen flow before its cover result
// is loaded, and its pass result follows once the output register is free. The
// search reads one flow entry per cycle through the memory read port. The cover
// result is followed by the pass result (last=1). The next packet can be accepted
// in the cycle after the pass result is loaded, so the output register lets a
// waiting result sit while the next packet is read.
module least_used_flow_cover_selector
    import lufcs_pkg::*;
#(
    parameter int FLOWS = LUFCS_FLOWS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_enable,
    input  logic [PROB_W-1:0] cfg_write_data,
    lufcs_pkt_if.sink        pkt,
    lufcs_res_if.source      res
);

    localparam int FLOW_W = (FLOWS > 1) ? $clog2(FLOWS) : 1;
    localparam int IDXW   = (FLOW_W > FLOW_INDEX_W) ? FLOW_W : FLOW_INDEX_W;
    localparam int ENTRY_W = ADDR_W + COUNT_W;
    localparam logic [FLOW_W-1:0] LAST_FLOW = FLOW_W'(FLOWS - 1);
    localparam logic [FLOW_W-1:0] FIRST_SCAN = FLOW_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OWN_RD,
        S_OWN_UPD,
        S_SCAN,
        S_DRAIN,
        S_FIN_RD,
        S_FIN_UPD,
        S_PASS
    } state_t;

    state_t                 state_reg;
    logic [PROB_W-1:0]      cover_prob_reg;
    logic [FLOWS-1:0]       valid_reg;

    // captured request
    logic [FLOW_W-1:0]      own_addr_reg;
    logic                   own_valid_reg;
    logic [ADDR_W-1:0]      src_reg;
    logic [LENGTH_W-1:0]    len_reg;
    logic [DRAW_W-1:0]      draw_reg;

    // search state
    logic [FLOW_W-1:0]      scan_idx_reg;
    logic                   cmp_valid_reg;
    logic [FLOW_W-1:0]      cmp_idx_reg;
    logic [COUNT_W-1:0]     best_count_reg;
    logic [FLOW_W-1:0]      best_flow_reg;

    // output register
    logic                    res_valid_reg;
    logic                    res_cover_reg;
    logic [FLOW_INDEX_W-1:0] res_flow_reg;
    logic [ADDR_W-1:0]       res_src_reg;
    logic                    res_last_reg;

    // memory and its port
    logic [ENTRY_W-1:0]     mem [FLOWS];
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_vld_reg;
    logic                   rd_en;
    logic [FLOW_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [FLOW_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]     wr_data;

    logic [IDXW-1:0]        in_flow_ext;
    logic [IDXW-1:0]        best_flow_ext;
    logic [COUNT_W-1:0]     rd_bytes;
    logic [ADDR_W-1:0]      rd_src;
    logic [COUNT_W-1:0]     own_new;
    logic [ADDR_W-1:0]      own_src_new;
    logic [COUNT_W-1:0]     fin_new;
    logic                   trigger;
    logic                   out_free;
    logic                   res_load;
    logic                   better;

    // flow index widened so any flow count can be addressed
    assign in_flow_ext   = IDXW'(pkt.flow_index);
    assign best_flow_ext = IDXW'(best_flow_reg);

    // read data, unwritten entries read as zero
    assign rd_bytes = rd_vld_reg ? rd_data_reg[COUNT_W-1:0] : '0;
    assign rd_src   = rd_vld_reg ? rd_data_reg[ENTRY_W-1:COUNT_W] : '0;

    // own flow update: latch source on an empty counter, then count the bytes
    assign own_new     = sat_add(rd_bytes, COUNT_W'(len_reg));
    assign own_src_new = (rd_bytes == '0) ? src_reg : rd_src;

    // cover flow update: packet length plus header bytes
    assign fin_new = sat_add(rd_bytes, COUNT_W'(len_reg) + COVER_HEADER_BYTES);

    assign trigger  = draw_reg < cover_prob_reg;
    assign out_free = !res_valid_reg || res.ready;
    assign res_load = out_free && (state_reg == S_FIN_UPD || state_reg == S_PASS);
    assign better   = cmp_valid_reg && (rd_bytes != '0) && (rd_bytes < best_count_reg);

    assign pkt.ready        = (state_reg == S_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.is_cover     = res_cover_reg;
    assign res.chosen_flow  = res_flow_reg;
    assign res.cover_source = res_src_reg;
    assign res.last         = res_last_reg;

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = own_addr_reg;
        mem_we  = 1'b0;
        wr_addr = own_addr_reg;
        wr_data = {own_src_new, own_new};
        case (state_reg)
            S_OWN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = own_addr_reg;
            end
            S_OWN_UPD:
            begin
                mem_we  = own_valid_reg;
                wr_addr = own_addr_reg;
                wr_data = {own_src_new, own_new};
            end
            S_SCAN:
            begin
                rd_en   = 1'b1;
                rd_addr = scan_idx_reg;
            end
            S_FIN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = best_flow_reg;
            end
            S_FIN_UPD:
            begin
                mem_we  = out_free;
                wr_addr = best_flow_reg;
                wr_data = {rd_src, fin_new};
            end
            default:
            begin
                rd_en  = 1'b0;
                mem_we = 1'b0;
            end
        endcase
    end

    // flow memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cover_prob_reg <= PROB_RESET;
            valid_reg      <= '0;
            own_addr_reg   <= '0;
            own_valid_reg  <= 1'b0;
            src_reg        <= '0;
            len_reg        <= '0;
            draw_reg       <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            best_count_reg <= '0;
            best_flow_reg  <= '0;
            res_valid_reg  <= 1'b0;
            res_cover_reg  <= 1'b0;
            res_flow_reg   <= '0;
            res_src_reg    <= '0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                cover_prob_reg <= cfg_write_data;
            end

            // output valid: set on a new result, cleared when taken
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            // compare stage of the search, one entry behind the read
            cmp_valid_reg <= (state_reg == S_SCAN);
            cmp_idx_reg   <= scan_idx_reg;
            if (better)
            begin
                best_count_reg <= rd_bytes;
                best_flow_reg  <= cmp_idx_reg;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (pkt.valid)
                    begin
                        own_addr_reg  <= in_flow_ext[FLOW_W-1:0];
                        own_valid_reg <= (int'(pkt.flow_index) < FLOWS);
                        src_reg       <= pkt.source_address;
                        len_reg       <= pkt.packet_length;
                        draw_reg      <= pkt.random_draw;
                        state_reg     <= S_OWN_RD;
                    end
                end
                S_OWN_RD:
                begin
                    state_reg <= S_OWN_UPD;
                end
                S_OWN_UPD:
                begin
                    if (own_valid_reg)
                    begin
                        valid_reg[own_addr_reg] <= 1'b1;
                    end
                    if (trigger)
                    begin
                        best_count_reg <= own_valid_reg ? own_new : {COUNT_W{1'b1}};
                        best_flow_reg  <= own_valid_reg ? own_addr_reg : FIRST_SCAN;
                        scan_idx_reg   <= FIRST_SCAN;
                        state_reg      <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_PASS;
                    end
                end
                S_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + FLOW_W'(1);
                    if (scan_idx_reg == LAST_FLOW)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FIN_RD;
                end
                S_FIN_RD:
                begin
                    state_reg <= S_FIN_UPD;
                end
                S_FIN_UPD:
                begin
                    if (out_free)
                    begin
                        valid_reg[best_flow_reg] <= 1'b1;
                        res_cover_reg <= 1'b1;
                        res_flow_reg  <= best_flow_ext[FLOW_INDEX_W-1:0];
                        res_src_reg   <= rd_src;
                        res_last_reg  <= 1'b0;
                        state_reg     <= S_PASS;
                    end
                end
                S_PASS:
                begin
                    if (out_free)
                    begin
                        res_cover_reg <= 1'b0;
                        res_flow_reg  <= '0;
                        res_src_reg   <= '0;
                        res_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a taken packet request closes the input until its results are queued
    ap_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        pkt.valid && pkt.ready |=> !pkt.ready)
        else $error("packet request accepted while another is in flight");

    // a delivered cover result is always followed by the pass result
    ap_cover_then_pass: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && res.is_cover |-> state_reg == S_PASS)
        else $error("cover result delivered without a pending pass result");

    // memory write never overlaps a read, so no entry is read stale
    ap_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !rd_en)
        else $error("flow memory read and write in the same cycle");

    // the search compare only runs during the scan and the drain state after it
    ap_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("search compare outside the scan");

endmodule

// File: tb/sv/least_used_flow_cover_selector_tb.sv
`timescale 1ns / 1ps
// testbench for the least-used flow cover selector: directed and random packet requests,
// each result checked against a behavioral copy of the flow counters and cover search
// depends on lufcs_pkg, lufcs_pkt_if, lufcs_res_if and least_used_flow_cover_selector

module least_used_flow_cover_selector_tb;
    import lufcs_pkg::*;

    localparam int MAX_GAP          = 14;
    localparam int LONG_HOLD        = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int STALL_LIMIT      = 3000;
    localparam int REPORT_LIMIT     = 10;
    localparam int LONG_ITEMS       = 40;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int RANDOM_PHASES    = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                    is_cover;
        logic [FLOW_INDEX_W-1:0] chosen_flow;
        logic [ADDR_W-1:0]       cover_source;
        logic                    last;
    } sel_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_enable;
    logic [PROB_W-1:0] cfg_write_data;

    lufcs_pkt_if pkt_ch ();
    lufcs_res_if res_ch ();

    least_used_flow_cover_selector i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .pkt              (pkt_ch),
        .res              (res_ch)
    );

    // shadow copy of the per-flow counters, latched sources and setting
    logic [COUNT_W-1:0] byte_count     [LUFCS_FLOWS];
    logic [ADDR_W-1:0]  latched_source [LUFCS_FLOWS];
    logic [PROB_W-1:0]  cover_pct;
    sel_result_t        awaited_results [$];

    int mismatches   = 0;
    int idle_cycles  = 0;
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    bit hold_request = 1'b0;

    always #5 clk = ~clk;

    // clamped 32-bit byte count addition
    function automatic logic [COUNT_W-1:0] add_clamped(
        input logic [COUNT_W-1:0] a,
        input logic [COUNT_W-1:0] b
    );
        logic [COUNT_W-1:0] sum;
        sum = a + b;
        return (sum < a) ? COUNT_MAX : sum;
    endfunction

    // update counters for one packet and queue its cover and pass results
    task automatic account_packet(
        input logic [FLOW_INDEX_W-1:0] flow,
        input logic [ADDR_W-1:0]       src,
        input logic [LENGTH_W-1:0]     len,
        input logic [DRAW_W-1:0]       draw
    );
        sel_result_t        r;
        logic [COUNT_W-1:0] best;
        int                 best_flow;
        bit                 own_ok;
        own_ok = (int'(flow) < LUFCS_FLOWS);
        if (own_ok)
        begin
            if (byte_count[flow] == '0)
                latched_source[flow] = src;
            byte_count[flow] = add_clamped(byte_count[flow], COUNT_W'(len));
        end
        if (draw < cover_pct)
        begin
            best_flow = own_ok ? int'(flow) : 1;
            best      = own_ok ? byte_count[flow] : COUNT_MAX;
            // strictly smaller nonzero count wins, so a tie keeps the own flow, else the lower flow
            for (int i = 1; i < LUFCS_FLOWS; i++)
            begin
                if (byte_count[i] != '0 && byte_count[i] < best)
                begin
                    best      = byte_count[i];
                    best_flow = i;
                end
            end
            r.is_cover     = 1'b1;
            r.chosen_flow  = FLOW_INDEX_W'(best_flow);
            r.cover_source = latched_source[best_flow];
            r.last         = 1'b0;
            awaited_results.push_back(r);
            byte_count[best_flow] = add_clamped(byte_count[best_flow],
                                                COUNT_W'(len) + COVER_HEADER_BYTES);
        end
        r      = '0;
        r.last = 1'b1;
        awaited_results.push_back(r);
    endtask

    // offer one packet request, after a random gap while tx_idle is set, and wait for its acceptance
    task automatic send_packet(
        input logic [FLOW_INDEX_W-1:0] flow,
        input logic [ADDR_W-1:0]       src,
        input logic [LENGTH_W-1:0]     len,
        input logic [DRAW_W-1:0]       draw
    );
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            pkt_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pkt_ch.valid          = 1'b1;
        pkt_ch.flow_index     = flow;
        pkt_ch.source_address = src;
        pkt_ch.packet_length  = len;
        pkt_ch.random_draw    = draw;
        do @(posedge clk); while (!pkt_ch.ready);
        account_packet(flow, src, len, draw);
        @(negedge clk);
        pkt_ch.valid = 1'b0;
    endtask

    // wait until every awaited result has come, then let the block settle
    task automatic wait_drained();
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_cover_probability(input logic [PROB_W-1:0] pct);
        wait_drained();
        cfg_write_enable = 1'b1;
        cfg_write_data   = pct;
        @(negedge clk);
        cfg_write_enable = 1'b0;
        cover_pct        = pct;
    endtask

    // random field pickers, biased to a few hot flows and short lengths for ties
    function automatic logic [FLOW_INDEX_W-1:0] pick_flow();
        if ($urandom_range(0, 3) == 0)
            return FLOW_INDEX_W'($urandom_range(0, LUFCS_FLOWS - 1));
        return FLOW_INDEX_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [LENGTH_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return LENGTH_W'($urandom_range(1, 8));
            4, 5, 6: return LENGTH_W'($urandom_range(0, 1500));
            7:       return '1;
            default: return LENGTH_W'($urandom);
        endcase
    endfunction

    function automatic logic [DRAW_W-1:0] pick_draw();
        if ($urandom_range(0, 7) == 0)
            return DRAW_W'($urandom_range(100, 127));
        return DRAW_W'($urandom_range(0, 99));
    endfunction

    // reset setting, then one flow fed back to back with maximum lengths, covers off
    task automatic test_long_packets();
        send_packet(6'd33, 32'h0A0B0C0D, 16'hFFFF, 7'd99);
        send_packet(6'd33, 32'h01020304, 16'hFFFF, 7'd100);
        set_cover_probability(7'd0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (LONG_ITEMS)
            send_packet(6'd33, $urandom, 16'hFFFF, DRAW_W'($urandom_range(0, 127)));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_cover_probability(7'd100);
        // flow 33 is the only nonzero one, so the cover goes back to it
        send_packet(6'd33, 32'hDEADBEEF, 16'd40000, 7'd0);
    endtask

    // search start, flow zero outside the scan, ties, zero lengths, field extremes
    task automatic test_search_rules();
        send_packet(6'd0,  32'h00000000, 16'd0,     7'd0);
        send_packet(6'd0,  32'hFFFFFFFF, 16'd10,    7'd127);
        send_packet(6'd63, 32'hFFFFFFFF, 16'hFFFF,  7'd99);
        send_packet(6'd5,  32'hC0A80005, 16'd100,   7'd0);
        send_packet(6'd6,  32'hC0A80006, 16'd254,   7'd0);
        send_packet(6'd7,  32'hC0A80007, 16'd300,   7'd0);
        send_packet(6'd10, 32'h0A00000A, 16'd500,   7'd100);
        send_packet(6'd11, 32'h0A00000B, 16'd500,   7'd100);
        send_packet(6'd9,  32'h0A000009, 16'd1000,  7'd0);
        send_packet(6'd5,  32'h55555555, 16'd0,     7'd0);
        send_packet(6'd20, 32'hAAAAAAAA, 16'd0,     7'd0);
        send_packet(6'd42, 32'h12345678, 16'd1,     7'd100);
        send_packet(6'd42, 32'h87654321, 16'd1,     7'd99);
        send_packet(6'd0,  32'h00000000, 16'd1,     7'd50);
    endtask

    // probability at zero, above 100 and at the draw boundary
    task automatic test_probability_extremes();
        set_cover_probability(7'd0);
        send_packet(6'd3, 32'h03030303, 16'd64, 7'd0);
        set_cover_probability(7'd127);
        send_packet(6'd4, 32'h04040404, 16'd64, 7'd126);
        send_packet(6'd4, 32'h04040405, 16'd64, 7'd127);
        set_cover_probability(7'd1);
        send_packet(6'd8, 32'h08080808, 16'd2, 7'd0);
        send_packet(6'd8, 32'h08080809, 16'd2, 7'd1);
        set_cover_probability(7'd100);
        send_packet(6'd12, 32'h0C0C0C0C, 16'd7, 7'd100);
    endtask

    task automatic test_random_traffic();
        logic [PROB_W-1:0] pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       pct = 7'd37;
                1:       pct = 7'd127;
                2:       pct = PROB_W'($urandom_range(0, 127));
                3:       pct = 7'd0;
                default: pct = 7'd100;
            endcase
            set_cover_probability(pct);
            tx_idle = (phase == RANDOM_PHASES - 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
            rx_idle = (phase == RANDOM_PHASES - 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
            repeat (RANDOM_PER_PHASE)
                send_packet(pick_flow(), $urandom, pick_length(), pick_draw());
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // result side holds off while requests keep coming, so the input stalls
    task automatic test_input_backpressure();
        tx_idle      = 1'b0;
        hold_request = 1'b1;
        repeat (12)
            send_packet(pick_flow(), $urandom, pick_length(), pick_draw());
        tx_idle = 1'b1;
    endtask

    // result side: random ready gaps plus an occasional long hold
    initial
    begin : result_sink
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                res_ch.ready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_request = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            @(negedge clk);
        end
    end

    task automatic note_mismatch(input string what, input sel_result_t want,
                                 input sel_result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t %s: exp c=%0d f=%0d s=%h l=%0d got c=%0d f=%0d s=%h l=%0d",
                     $realtime, what, want.is_cover, want.chosen_flow, want.cover_source,
                     want.last, got.is_cover, got.chosen_flow, got.cover_source, got.last);
    endtask

    // compare every accepted result with the oldest awaited one
    always @(posedge clk)
    begin : result_check
        sel_result_t want;
        sel_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got.is_cover     = res_ch.is_cover;
            got.chosen_flow  = res_ch.chosen_flow;
            got.cover_source = res_ch.cover_source;
            got.last         = res_ch.last;
            if (awaited_results.size() == 0)
                note_mismatch("result with nothing awaited", '0, got);
            else
            begin
                want = awaited_results.pop_front();
                if (got.is_cover !== want.is_cover || got.chosen_flow !== want.chosen_flow
                    || got.cover_source !== want.cover_source || got.last !== want.last)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("timeout: no handshake for %0d cycles", idle_cycles);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_write_enable      = 1'b0;
        cfg_write_data        = '0;
        pkt_ch.valid          = 1'b0;
        pkt_ch.flow_index     = '0;
        pkt_ch.source_address = '0;
        pkt_ch.packet_length  = '0;
        pkt_ch.random_draw    = '0;
        cover_pct             = PROB_RESET;
        for (int i = 0; i < LUFCS_FLOWS; i++)
        begin
            byte_count[i]     = '0;
            latched_source[i] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_long_packets();
        test_search_rules();
        test_probability_extremes();
        test_random_traffic();
        test_input_backpressure();

        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/lufcs_pkg.sv
hw/rtl/lufcs_pkt_if.sv
hw/rtl/lufcs_res_if.sv
hw/rtl/least_used_flow_cover_selector.sv
tb/sv/least_used_flow_cover_selector_tb.sv
